// ----- rtl/core/fpf_pkg.sv -----
// Shared types and constants for the fingerprint command packet framer.
package fpf_pkg;

   // Largest payload (command code included) that a packet may announce.
   localparam int MAX_PAYLOAD = 64;
   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  HEAD_HI    = 8'hEF;
   localparam logic [7:0]  HEAD_LO    = 8'h01;
   localparam logic [7:0]  CMD_FLAG   = 8'h01;
   localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

   // Byte positions within one packet as the back end walks them.
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_HEAD_HI = 4'd0;
   localparam logic [POS_W-1:0] POS_HEAD_LO = 4'd1;
   localparam logic [POS_W-1:0] POS_ADDR_3  = 4'd2;
   localparam logic [POS_W-1:0] POS_ADDR_2  = 4'd3;
   localparam logic [POS_W-1:0] POS_ADDR_1  = 4'd4;
   localparam logic [POS_W-1:0] POS_ADDR_0  = 4'd5;
   localparam logic [POS_W-1:0] POS_FLAG    = 4'd6;
   localparam logic [POS_W-1:0] POS_LEN_HI  = 4'd7;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 4'd8;
   localparam logic [POS_W-1:0] POS_DATA    = 4'd9;
   localparam logic [POS_W-1:0] POS_SUM_HI  = 4'd10;
   localparam logic [POS_W-1:0] POS_SUM_LO  = 4'd11;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       first_of_packet;
      logic [6:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       packet_end;
   } rsp_type;

   // One classified item handed from front to back.
   typedef struct packed {
      logic        has_header;
      logic        has_checksum;
      logic [7:0]  data;
      logic [15:0] length;
      logic [15:0] checksum;
      logic [31:0] address;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- rtl/core/fpf_chan_if.sv -----
// Valid/ready channel interface carrying one payload word per handshake.
interface fpf_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/fpf_front.sv -----
// Front end: accepts input words, tracks packet state and classifies each word.
module fpf_front import fpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   fpf_chan_if.sink          req_chan,
   input  logic [31:0]       module_address,
   input  queue_status_type  q_status,
   output logic              push,
   output job_type           push_job
);

   logic [6:0]  rem_ff, rem_in;
   logic [15:0] sum_ff, sum_in;
   logic        open_ff, open_in;

   logic        accept, first;
   logic [6:0]  plen_raw, plen_eff, rem_cur, rem_next;
   logic [15:0] length, base_sum, new_sum;
   logic        closes;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign first          = req_chan.payload.first_of_packet;

   always_comb begin
      plen_raw = req_chan.payload.payload_length;
      // force at least the command code, clamp to the largest payload
      if (plen_raw == 7'd0) begin
         plen_eff = 7'd1;
      end else if ({1'b0, plen_raw} > 8'(MAX_PAYLOAD)) begin
         plen_eff = 7'(MAX_PAYLOAD);
      end else begin
         plen_eff = plen_raw;
      end
      length   = 16'(plen_eff) + 16'd2;
      base_sum = 16'(CMD_FLAG) + {8'h00, length[15:8]} + {8'h00, length[7:0]};
      new_sum  = (first ? base_sum : sum_ff) + 16'(req_chan.payload.payload_byte);
      rem_cur  = first ? plen_eff : rem_ff;
      rem_next = (rem_cur != 7'd0) ? (rem_cur - 7'd1) : 7'd0;
      closes   = (rem_next == 7'd0);
   end

   // drop stray words that arrive with no packet open
   assign push = accept && (first || open_ff);

   always_comb begin
      push_job.has_header   = first;
      push_job.has_checksum = closes;
      push_job.data         = req_chan.payload.payload_byte;
      push_job.length       = length;
      push_job.checksum     = new_sum;
      push_job.address      = module_address;
   end

   always_comb begin
      rem_in  = rem_ff;
      sum_in  = sum_ff;
      open_in = open_ff;
      if (push) begin
         rem_in  = rem_next;
         sum_in  = closes ? 16'd0 : new_sum;
         open_in = !closes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         sum_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         rem_ff  <= rem_in;
         sum_ff  <= sum_in;
         open_ff <= open_in;
      end
   end

endmodule

// ----- rtl/core/fpf_queue.sv -----
// Small FIFO of classified jobs between the front and back ends.
module fpf_queue import fpf_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           head_job,
   output queue_status_type  q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_job       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/fpf_back.sv -----
// Back end: walks each job's bytes into a registered output stage.
module fpf_back import fpf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  job_type           head_job,
   input  queue_status_type  q_status,
   output logic              pop,
   fpf_chan_if.source        rsp_chan
);

   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic             out_free, emit, last;
   logic [POS_W-1:0] pos, end_pos;
   rsp_type          next_rsp;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = out_free && !q_status.empty;
   assign pos      = active_ff ? pos_ff : (head_job.has_header ? POS_HEAD_HI : POS_DATA);
   assign end_pos  = head_job.has_checksum ? POS_SUM_LO : POS_DATA;
   assign last     = (pos == end_pos);
   assign pop      = emit && last;

   always_comb begin
      next_rsp.out_byte = head_job.data;
      unique case (pos)
         POS_HEAD_HI: next_rsp.out_byte = HEAD_HI;
         POS_HEAD_LO: next_rsp.out_byte = HEAD_LO;
         POS_ADDR_3:  next_rsp.out_byte = head_job.address[31:24];
         POS_ADDR_2:  next_rsp.out_byte = head_job.address[23:16];
         POS_ADDR_1:  next_rsp.out_byte = head_job.address[15:8];
         POS_ADDR_0:  next_rsp.out_byte = head_job.address[7:0];
         POS_FLAG:    next_rsp.out_byte = CMD_FLAG;
         POS_LEN_HI:  next_rsp.out_byte = head_job.length[15:8];
         POS_LEN_LO:  next_rsp.out_byte = head_job.length[7:0];
         POS_DATA:    next_rsp.out_byte = head_job.data;
         POS_SUM_HI:  next_rsp.out_byte = head_job.checksum[15:8];
         POS_SUM_LO:  next_rsp.out_byte = head_job.checksum[7:0];
         default:     next_rsp.out_byte = head_job.data;
      endcase
      next_rsp.last_of_run = last;
      next_rsp.packet_end  = (pos == POS_SUM_LO);
   end

   always_comb begin
      active_in    = active_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         active_in    = !last;
         pos_in       = pos + POS_W'(1);
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= next_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// ----- rtl/core/fingerprint_command_packet_framer.sv -----
// Command packet framer for a serial fingerprint sensor module: top level.
//
// Feed payload words on req_chan, the command code first with first_of_packet set and
// payload_length giving the payload count (0 counts as 1, values above MAX_PAYLOAD are
// clamped). On the first word the block sends EF 01, the module address big-endian, the
// flag 01 and the length (count + 2) big-endian, then the command code; later words pass
// through; after the last payload word come the 16-bit checksum high and low bytes, the
// low byte flagged packet_end. last_of_run marks the last byte caused by each word. A
// word with first_of_packet clear and no packet open is dropped; a new first word
// abandons an open packet without a checksum. Rate: the front takes one word per cycle
// while the job queue (QUEUE_DEPTH entries) has room; the back sequencer sends one byte
// per cycle while rsp_chan is ready; a framed word yields 1 to 12 bytes (12 for a
// one-byte packet, 10 for an opener, 3 for a closer, 1 otherwise); a dropped stray word
// yields none; that byte sequencer sets the sustained rate. Write module_address on
// csr_chan only while idle; it is always ready and resets to FFFFFFFF.
module fingerprint_command_packet_framer import fpf_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fpf_chan_if.sink    req_chan,
   fpf_chan_if.source  rsp_chan,
   fpf_chan_if.sink    csr_chan
);

   logic [31:0]      addr_ff, addr_in;
   logic             push, pop;
   job_type          push_job, head_job;
   queue_status_type q_status;

   // Configuration: take every word, hold the address between writes.
   assign csr_chan.ready = 1'b1;
   assign addr_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.payload : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else begin
         addr_ff <= addr_in;
      end
   end

   // Classify words and advance the packet state.
   fpf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .module_address (addr_ff),
      .q_status       (q_status),
      .push           (push),
      .push_job       (push_job)
   );

   // Decouple the word intake from the byte output.
   fpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // Expand each job into its output bytes.
   fpf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // A packet close is always the last byte of its run.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.packet_end |-> rsp_chan.payload.last_of_run)
      else $error("packet_end without last_of_run");

   // Never push into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full job queue");

   // Never pop an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty job queue");

   // Output stage is empty after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("rsp valid after reset");

endmodule
